[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define BVT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bvt assertion failed");

// Clocked assertion that also runs through reset.
`define BVT_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bvt assertion failed");

`endif

[hw/rtl/bvt_pkg.sv]
package bvt_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int HEIGHT_W = 32;
    localparam int VIEW_W   = 5;
    localparam int SENDER_W = 6;
    localparam int COUNT_W  = 7;
    localparam int NODES_W  = 7;
    localparam int ID_W     = 6;
    localparam int BTIME_W  = 16;
    localparam int TICKS_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [NODES_W-1:0] NODES_RST = 7'd4;
    localparam logic [ID_W-1:0]    ID_RST    = 6'd0;
    localparam logic [BTIME_W-1:0] BTIME_RST = 16'd1000;
    localparam logic [VIEW_W-1:0]  VIEW_LAST = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_OWN_ID     = 2'd1,
        CFG_BLOCK_TIME = 2'd2
    } t_cfg_idx;

    typedef enum logic [0:0] {
        REQ_MESSAGE = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_PREP_REQUEST  = 2'd0,
        KIND_PREP_RESPONSE = 2'd1,
        KIND_CHANGE_VIEW   = 2'd2,
        KIND_PUBLISHED     = 2'd3
    } t_msg_kind;

    typedef enum logic [2:0] {
        OUT_PENDING      = 3'd0,
        OUT_IGNORED      = 3'd1,
        OUT_COMMIT_VOTE  = 3'd2,
        OUT_COMMIT_BLOCK = 3'd3,
        OUT_REJECT_VIEW  = 3'd4,
        OUT_TIMEOUT_VIEW = 3'd5,
        OUT_EXHAUST_VIEW = 3'd6
    } t_outcome;

    // Request and status between the sequencer and the serial modulo unit.
    typedef struct packed {
        logic                start;
        logic [HEIGHT_W-1:0] dividend;
        logic [NODES_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic               done;
        logic [NODES_W-1:0] rem;
    } t_mod_rsp;

endpackage

[hw/rtl/bvt_if.sv]
interface bvt_req_if;
    import bvt_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          req_type;
    logic [1:0]          msg_kind;
    logic [HEIGHT_W-1:0] msg_height;
    logic [VIEW_W-1:0]   msg_view;
    logic [SENDER_W-1:0] sender_id;

    modport source (output valid, req_type, msg_kind, msg_height, msg_view, sender_id,
                    input ready);
    modport sink   (input valid, req_type, msg_kind, msg_height, msg_view, sender_id,
                    output ready);
endinterface

interface bvt_rsp_if;
    import bvt_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          outcome;
    logic [HEIGHT_W-1:0] height;
    logic [VIEW_W-1:0]   view_now;
    logic                is_speaker;
    logic [COUNT_W-1:0]  approve_total;
    logic [COUNT_W-1:0]  reject_total;

    modport source (output valid, outcome, height, view_now, is_speaker, approve_total,
                    reject_total, input ready);
    modport sink   (input valid, outcome, height, view_now, is_speaker, approve_total,
                    reject_total, output ready);
endinterface

interface bvt_cfg_if;
    import bvt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/bvt_mod_unit.sv]
module bvt_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bvt_pkg::t_mod_req i_req,
    output bvt_pkg::t_mod_rsp o_rsp
);
    import bvt_pkg::*;

    localparam int CNT_W = $clog2(HEIGHT_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [HEIGHT_W-1:0] r_quo, n_quo;
    logic [NODES_W-1:0]  r_rem, n_rem;
    logic [NODES_W-1:0]  r_div, n_div;
    logic [NODES_W:0]    trial;

    // One quotient bit per cycle, restoring: remainder stays below the divisor.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_quo[HEIGHT_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(HEIGHT_W - 1);
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = NODES_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[NODES_W-1:0];
            end
            n_quo = {r_quo[HEIGHT_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/bft_vote_tally.sv]
// Supermajority vote tally for one consensus node. Each request is a consensus
// message or one time tick; each yields exactly one response with the outcome,
// the height and view after the step, the vote totals and the speaker flag
// ((height - view) mod N == own id). A request is latched on acceptance, the
// tally is updated in the evaluate state, the bit-serial modulo unit then forms
// the speaker test, and the response is loaded from the load state. The
// next request is taken once the response is loaded into the output register,
// even if the sink has not yet taken it. Configuration writes are always
// accepted and should only be issued while no request is in flight.
module bft_vote_tally #(
    parameter int MAX_NODES = bvt_pkg::MAX_NODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bvt_req_if.sink   i_req,
    bvt_cfg_if.sink   i_cfg,
    bvt_rsp_if.source o_rsp
);
    import bvt_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LIM_W = BTIME_W + HEIGHT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_MOD  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [NODES_W-1:0] r_node_count;
    logic [ID_W-1:0]    r_own_id;
    logic [BTIME_W-1:0] r_block_time;

    logic [0:0]          r_in_type;
    logic [1:0]          r_in_kind;
    logic [HEIGHT_W-1:0] r_in_height;
    logic [VIEW_W-1:0]   r_in_view;
    logic [SENDER_W-1:0] r_in_sender;

    logic [MAX_NODES-1:0] r_appr_set, n_appr_set;
    logic [MAX_NODES-1:0] r_rej_set, n_rej_set;
    logic [COUNT_W-1:0]   r_appr_cnt, n_appr_cnt;
    logic [COUNT_W-1:0]   r_rej_cnt, n_rej_cnt;
    logic [HEIGHT_W-1:0]  r_height, n_height;
    logic [VIEW_W-1:0]    r_view, n_view;
    logic [TICKS_W-1:0]   r_elapsed, n_elapsed;
    t_outcome             r_outcome, n_outcome;

    logic                r_out_valid;
    t_outcome            r_out_outcome;
    logic [HEIGHT_W-1:0] r_out_height;
    logic [VIEW_W-1:0]   r_out_view;
    logic                r_out_speaker;
    logic [COUNT_W-1:0]  r_out_appr;
    logic [COUNT_W-1:0]  r_out_rej;

    logic [NODES_W-1:0]   eff_nodes;
    logic [TICKS_W-1:0]   ticks_inc;
    logic [LIM_W-1:0]     tick_limit;
    logic [VIEW_W-1:0]    view_adv;
    logic [MAX_NODES-1:0] sender_bit;
    logic [COUNT_W-1:0]   appr_inc, rej_inc;
    logic [COUNT_W+1:0]   appr_x3, rej_x3, nodes_x2;
    logic [COUNT_W:0]     vote_sum;
    logic                 counted;

    logic     req_fire, cfg_fire, can_load;
    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    assign req_fire = i_req.valid && i_req.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign can_load = !r_out_valid || o_rsp.ready;

    // Clamp the node count to 1..MAX_NODES.
    always_comb begin
        priority if (r_node_count == '0) begin
            eff_nodes = NODES_W'(1);
        end else if (r_node_count > NODES_W'(MAX_NODES)) begin
            eff_nodes = NODES_W'(MAX_NODES);
        end else begin
            eff_nodes = r_node_count;
        end
    end

    assign ticks_inc  = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICKS_W'(1);
    assign tick_limit = LIM_W'(r_block_time) << ({1'b0, r_view} + 6'd1);
    assign view_adv   = (r_view == VIEW_LAST) ? r_view : r_view + VIEW_W'(1);
    assign sender_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_in_sender[IDX_W-1:0];

    // Tally update for the latched request.
    always_comb begin
        n_appr_set = r_appr_set;
        n_rej_set  = r_rej_set;
        n_appr_cnt = r_appr_cnt;
        n_rej_cnt  = r_rej_cnt;
        n_height   = r_height;
        n_view     = r_view;
        n_elapsed  = r_elapsed;
        n_outcome  = OUT_PENDING;
        counted    = 1'b0;
        appr_inc   = r_appr_cnt;
        rej_inc    = r_rej_cnt;

        if (r_in_type == REQ_TICK) begin
            n_elapsed = ticks_inc;
            if (LIM_W'(ticks_inc) > tick_limit) begin
                n_outcome = OUT_TIMEOUT_VIEW;
            end
        end else if (r_in_height != r_height || r_in_view != r_view) begin
            n_outcome = OUT_IGNORED;
        end else if (r_in_kind == KIND_PUBLISHED) begin
            n_outcome = OUT_COMMIT_BLOCK;
        end else if ({1'b0, r_in_sender} >= eff_nodes) begin
            n_outcome = OUT_IGNORED;
        end else if (r_in_kind == KIND_CHANGE_VIEW) begin
            if ((r_rej_set & sender_bit) == '0) begin
                n_rej_set = r_rej_set | sender_bit;
                rej_inc   = r_rej_cnt + COUNT_W'(1);
                n_rej_cnt = rej_inc;
                counted   = 1'b1;
            end
        end else begin
            if ((r_appr_set & sender_bit) == '0) begin
                n_appr_set = r_appr_set | sender_bit;
                appr_inc   = r_appr_cnt + COUNT_W'(1);
                n_appr_cnt = appr_inc;
                counted    = 1'b1;
            end
        end

        appr_x3  = (COUNT_W+2)'(appr_inc) * (COUNT_W+2)'(3);
        rej_x3   = (COUNT_W+2)'(rej_inc) * (COUNT_W+2)'(3);
        nodes_x2 = {1'b0, eff_nodes, 1'b0};
        vote_sum = {1'b0, appr_inc} + {1'b0, rej_inc};

        if (counted) begin
            priority if (appr_x3 > nodes_x2) begin
                n_outcome = OUT_COMMIT_VOTE;
            end else if (rej_x3 > nodes_x2) begin
                n_outcome = OUT_REJECT_VIEW;
            end else if (vote_sum >= {1'b0, eff_nodes}) begin
                n_outcome = OUT_EXHAUST_VIEW;
            end
        end

        if (n_outcome == OUT_COMMIT_VOTE || n_outcome == OUT_COMMIT_BLOCK) begin
            n_height = r_height + HEIGHT_W'(1);
            n_view   = '0;
        end else if (n_outcome == OUT_REJECT_VIEW || n_outcome == OUT_TIMEOUT_VIEW
                     || n_outcome == OUT_EXHAUST_VIEW) begin
            n_view = view_adv;
        end
        if (n_outcome != OUT_PENDING && n_outcome != OUT_IGNORED) begin
            n_appr_set = '0;
            n_rej_set  = '0;
            n_appr_cnt = '0;
            n_rej_cnt  = '0;
            n_elapsed  = '0;
        end
    end

    assign mod_req.start    = (r_state == S_EVAL);
    assign mod_req.dividend = n_height - HEIGHT_W'(n_view);
    assign mod_req.divisor  = eff_nodes;

    bvt_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) n_state = S_EVAL;
            S_EVAL: n_state = S_MOD;
            S_MOD:  if (mod_rsp.done) n_state = S_LOAD;
            S_LOAD: if (can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODES_RST;
            r_own_id     <= ID_RST;
            r_block_time <= BTIME_RST;
            r_appr_set   <= '0;
            r_rej_set    <= '0;
            r_appr_cnt   <= '0;
            r_rej_cnt    <= '0;
            r_height     <= '0;
            r_view       <= '0;
            r_elapsed    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                unique case (i_cfg.index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg.data[NODES_W-1:0];
                    CFG_OWN_ID:     r_own_id     <= i_cfg.data[ID_W-1:0];
                    CFG_BLOCK_TIME: r_block_time <= i_cfg.data[BTIME_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_EVAL) begin
                r_appr_set <= n_appr_set;
                r_rej_set  <= n_rej_set;
                r_appr_cnt <= n_appr_cnt;
                r_rej_cnt  <= n_rej_cnt;
                r_height   <= n_height;
                r_view     <= n_view;
                r_elapsed  <= n_elapsed;
            end
            // Hold the response until taken; refill only from the load state.
            if (r_state == S_LOAD && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (req_fire) begin
            r_in_type   <= i_req.req_type;
            r_in_kind   <= i_req.msg_kind;
            r_in_height <= i_req.msg_height;
            r_in_view   <= i_req.msg_view;
            r_in_sender <= i_req.sender_id;
        end
        if (r_state == S_EVAL) begin
            r_outcome <= n_outcome;
        end
        if (r_state == S_LOAD && can_load) begin
            r_out_outcome <= r_outcome;
            r_out_height  <= r_height;
            r_out_view    <= r_view;
            r_out_speaker <= (mod_rsp.rem == {1'b0, r_own_id});
            r_out_appr    <= r_appr_cnt;
            r_out_rej     <= r_rej_cnt;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.outcome       = r_out_outcome;
    assign o_rsp.height        = r_out_height;
    assign o_rsp.view_now      = r_out_view;
    assign o_rsp.is_speaker    = r_out_speaker;
    assign o_rsp.approve_total = r_out_appr;
    assign o_rsp.reject_total  = r_out_rej;

endmodule

[hw/rtl/bvt_checker.sv]
`include "assert_macros.svh"

module bvt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [2:0]                   i_outcome,
    input logic [bvt_pkg::HEIGHT_W-1:0] i_height,
    input logic [bvt_pkg::VIEW_W-1:0]   i_view_now,
    input logic [bvt_pkg::COUNT_W-1:0]  i_approve_total,
    input logic [bvt_pkg::COUNT_W-1:0]  i_reject_total
);
    import bvt_pkg::*;

    logic rsp_decided;
    logic rsp_commit;
    logic totals_zero;
    logic rsp_stalled;

    assign rsp_commit  = i_outcome == OUT_COMMIT_VOTE || i_outcome == OUT_COMMIT_BLOCK;
    assign rsp_decided = rsp_commit || i_outcome == OUT_REJECT_VIEW
                         || i_outcome == OUT_TIMEOUT_VIEW || i_outcome == OUT_EXHAUST_VIEW;
    assign totals_zero = i_approve_total == '0 && i_reject_total == '0;
    assign rsp_stalled = i_rsp_valid && !i_rsp_ready;

    `BVT_ASSERT_ANY(a_rst_no_rsp, i_clk, !i_rst_n |=> !i_rsp_valid)
    `BVT_ASSERT(a_outcome_code, i_clk, i_rst_n, i_rsp_valid |-> i_outcome <= OUT_EXHAUST_VIEW)
    `BVT_ASSERT(a_decide_clears, i_clk, i_rst_n, (i_rsp_valid && rsp_decided) |-> totals_zero)
    `BVT_ASSERT(a_commit_view0, i_clk, i_rst_n, (i_rsp_valid && rsp_commit) |-> i_view_now == '0)
    `BVT_ASSERT(a_stall_hold, i_clk, i_rst_n, rsp_stalled |=> (i_rsp_valid && $stable(i_height)))

endmodule

bind bft_vote_tally bvt_checker u_bvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_outcome       (o_rsp.outcome),
    .i_height        (o_rsp.height),
    .i_view_now      (o_rsp.view_now),
    .i_approve_total (o_rsp.approve_total),
    .i_reject_total  (o_rsp.reject_total)
);
